>>> rtl/dlpm_pkg.sv
package dlpm_pkg;

    // table geometry
    localparam int STATES   = 64;
    localparam int SLOTS    = 16;
    localparam int MAX_LEN  = 32768;

    localparam int STATE_W  = $clog2(STATES);
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int BYTE_W   = 8;
    // slot entry: {valid, low, high, target}
    localparam int ENTRY_W  = 1 + 2 * BYTE_W + STATE_W;
    localparam int BR_W     = SLOTS * ENTRY_W;
    // one row per state: all slots plus the accept flag on top
    localparam int ROW_W    = BR_W + 1;
    localparam int ACC_BIT  = ROW_W - 1;

    localparam int BC_W     = $clog2(MAX_LEN + 1);
    localparam int OFF_W    = 15;
    localparam int POS_W    = 16;
    localparam int IDX_W    = 17;
    localparam int CFG_W    = 15;

    typedef enum logic [1:0] {
        OP_BRANCH = 2'd0,
        OP_ACCEPT = 2'd1,
        OP_SCAN   = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_START_STATE  = 1'b0,
        CFG_START_OFFSET = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRB,
        ST_RES,
        ST_WRA,
        ST_LOOK,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [STATE_W-1:0] target;
    } t_hit;

endpackage

>>> rtl/dlpm_ram.sv
module dlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/dlpm_match.sv
// First valid slot (lowest index) whose inclusive range holds the byte.
module dlpm_match (
    input  logic [dlpm_pkg::BR_W-1:0]   i_branches,
    input  logic [dlpm_pkg::BYTE_W-1:0] i_byte,
    output dlpm_pkg::t_hit              o_hit
);

    logic [dlpm_pkg::ENTRY_W-1:0] entry;
    logic [dlpm_pkg::BYTE_W-1:0]  lo;
    logic [dlpm_pkg::BYTE_W-1:0]  hi;

    always_comb begin
        o_hit = '0;
        entry = '0;
        lo    = '0;
        hi    = '0;
        // scan high to low so the lowest hit lands last
        for (int k = dlpm_pkg::SLOTS - 1; k >= 0; k--) begin
            entry = i_branches[k*dlpm_pkg::ENTRY_W +: dlpm_pkg::ENTRY_W];
            lo    = entry[dlpm_pkg::ENTRY_W-2 -: dlpm_pkg::BYTE_W];
            hi    = entry[dlpm_pkg::ENTRY_W-2-dlpm_pkg::BYTE_W -: dlpm_pkg::BYTE_W];
            if (entry[dlpm_pkg::ENTRY_W-1] && (i_byte >= lo) && (i_byte <= hi)) begin
                o_hit.hit    = 1'b1;
                o_hit.target = entry[dlpm_pkg::STATE_W-1:0];
            end
        end
    end

endmodule

>>> rtl/dfa_longest_prefix_matcher.sv
// DFA longest-prefix matcher.
// Input channel (i_in_valid / o_in_stall): one transaction per opcode. Branch and
// accept-flag writes load the table; scan bytes run the loaded DFA; a byte with
// i_last_byte set, or a finish opcode, ends the string and yields one result.
// Output channel (o_out_valid / i_out_stall): one result transaction per string.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): start state and start
// offset; the state is picked up at the start of the next string, the offset at each use.
// Throughput: one transaction in flight. A scan byte reads the row of the current
// state, then matches the slots. A last byte that takes a branch needs a second
// row read for the target's accept flag before the result register is loaded.
// Branch writes do a row read-modify-write; accept writes do too, with an extra
// row read first when an accept check from the previous byte is still open. The
// row RAM's registered read sets these steps.
// The result sits in an output register, so a new transaction is taken while the
// receiver stalls; only a second result waits until the first is taken.
// Reset (synchronous, i_rst_n low) marks every table row empty (all slots
// invalid, accept flag clear) through per-row valid bits; no clearing pass.
module dfa_longest_prefix_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [5:0]                   i_table_state,
    input  logic [3:0]                   i_slot,
    input  logic                         i_slot_valid,
    input  logic [7:0]                   i_range_low,
    input  logic [7:0]                   i_range_high,
    input  logic [5:0]                   i_target_state,
    input  logic                         i_accepting,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_last_byte,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_matched,
    output logic                         o_any_prefix,
    output logic signed [16:0]           o_last_index,
    output logic                         o_died,
    // config channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [dlpm_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int SW = dlpm_pkg::STATE_W;

    // control
    dlpm_pkg::t_state r_state, n_state;
    logic [dlpm_pkg::STATES-1:0] r_row_vld;
    logic                        r_rd_vld;

    // config
    logic [SW-1:0]                r_start_state;
    logic [dlpm_pkg::OFF_W-1:0]   r_start_off;

    // scan context
    logic [SW-1:0]                r_cur, n_cur;
    logic                         r_dead, n_dead;
    logic                         r_seen, n_seen;
    logic [dlpm_pkg::BC_W-1:0]    r_bc, n_bc;
    logic [dlpm_pkg::IDX_W-1:0]   r_lai, n_lai;
    // accept check of the state just entered, resolved at its next row read
    logic                         r_pend, n_pend;
    logic [dlpm_pkg::POS_W-1:0]   r_ppos, n_ppos;

    // latched transaction
    dlpm_pkg::t_op                r_op;
    logic [SW-1:0]                r_ts;
    logic [dlpm_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_sv;
    logic [7:0]                   r_lo;
    logic [7:0]                   r_hi;
    logic [SW-1:0]                r_tgt;
    logic                         r_acc;
    logic [7:0]                   r_byte;
    logic                         r_last;

    // pending result and output register
    logic                         r_res_m, n_res_m;
    logic                         r_res_any, n_res_any;
    logic [dlpm_pkg::IDX_W-1:0]   r_res_lai, n_res_lai;
    logic                         r_res_died, n_res_died;
    logic                         r_out_vld, n_out_vld;
    logic                         r_out_m;
    logic                         r_out_any;
    logic [dlpm_pkg::IDX_W-1:0]   r_out_lai;
    logic                         r_out_died;

    // RAM ports
    logic                         rd_en;
    logic [SW-1:0]                rd_addr;
    logic                         wr_en;
    logic [SW-1:0]                wr_addr;
    logic [dlpm_pkg::ROW_W-1:0]   wr_data;
    logic [dlpm_pkg::ROW_W-1:0]   ram_q;
    logic [dlpm_pkg::ROW_W-1:0]   row_q;

    dlpm_pkg::t_op                in_op;
    dlpm_pkg::t_hit               hit;
    logic                         in_acc;
    logic                         out_free;
    logic                         begin_str;
    logic                         flag;
    logic                         skip;
    logic                         take;
    logic                         s_seen;
    logic                         s_dead;
    logic [dlpm_pkg::IDX_W-1:0]   s_lai;
    logic [dlpm_pkg::IDX_W-1:0]   off_m1;
    logic [dlpm_pkg::IDX_W-1:0]   pos_sum;
    logic [dlpm_pkg::POS_W-1:0]   pos_sat;

    assign in_op       = dlpm_pkg::t_op'(i_opcode);
    assign in_acc      = i_in_valid && (r_state == dlpm_pkg::ST_IDLE);
    assign o_in_stall  = (r_state != dlpm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;

    // never-written rows read as empty
    assign row_q = r_rd_vld ? ram_q : '0;

    dlpm_ram #(
        .WIDTH (dlpm_pkg::ROW_W),
        .DEPTH (dlpm_pkg::STATES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    dlpm_match u_match (
        .i_branches (row_q[dlpm_pkg::BR_W-1:0]),
        .i_byte     (r_byte),
        .o_hit      (hit)
    );

    // string-start and accept-check resolution against the row just read
    assign begin_str = (r_bc == '0);
    assign flag      = row_q[dlpm_pkg::ACC_BIT];
    assign off_m1    = {2'b00, r_start_off} - dlpm_pkg::IDX_W'(1);
    assign s_seen    = begin_str ? flag : (r_seen || (r_pend && flag));
    assign s_lai     = begin_str ? off_m1 :
                       ((r_pend && flag) ? {1'b0, r_ppos} : r_lai);
    assign s_dead    = begin_str ? 1'b0 : r_dead;
    assign skip      = s_dead || (r_bc == dlpm_pkg::BC_W'(dlpm_pkg::MAX_LEN));
    assign take      = !skip && hit.hit;

    assign pos_sum = dlpm_pkg::IDX_W'(r_start_off) + dlpm_pkg::IDX_W'(r_bc);
    assign pos_sat = pos_sum[dlpm_pkg::POS_W] ? '1 : pos_sum[dlpm_pkg::POS_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dlpm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        dlpm_pkg::OP_BRANCH: n_state = dlpm_pkg::ST_WRB;
                        dlpm_pkg::OP_ACCEPT: n_state = r_pend ? dlpm_pkg::ST_RES
                                                              : dlpm_pkg::ST_WRA;
                        default:             n_state = dlpm_pkg::ST_LOOK;
                    endcase
                end
            end
            dlpm_pkg::ST_WRB: n_state = dlpm_pkg::ST_IDLE;
            dlpm_pkg::ST_WRA: n_state = dlpm_pkg::ST_IDLE;
            dlpm_pkg::ST_RES: n_state = dlpm_pkg::ST_WRA;
            dlpm_pkg::ST_LOOK: begin
                if (r_op == dlpm_pkg::OP_FINISH) begin
                    n_state = dlpm_pkg::ST_EMIT;
                end else if (!r_last) begin
                    n_state = dlpm_pkg::ST_IDLE;
                end else if (take) begin
                    n_state = dlpm_pkg::ST_FIN;
                end else begin
                    n_state = dlpm_pkg::ST_EMIT;
                end
            end
            dlpm_pkg::ST_FIN: n_state = dlpm_pkg::ST_EMIT;
            dlpm_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = dlpm_pkg::ST_IDLE;
                end
            end
            default: n_state = dlpm_pkg::ST_IDLE;
        endcase
    end

    // RAM access
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cur;
        wr_en   = 1'b0;
        wr_addr = r_ts;
        wr_data = row_q;
        case (r_state)
            dlpm_pkg::ST_IDLE: begin
                rd_en = in_acc;
                case (in_op)
                    dlpm_pkg::OP_BRANCH: rd_addr = i_table_state;
                    dlpm_pkg::OP_ACCEPT: rd_addr = r_pend ? r_cur : i_table_state;
                    default:             rd_addr = begin_str ? r_start_state : r_cur;
                endcase
            end
            dlpm_pkg::ST_RES: begin
                rd_en   = 1'b1;
                rd_addr = r_ts;
            end
            dlpm_pkg::ST_LOOK: begin
                rd_en   = (r_op == dlpm_pkg::OP_SCAN) && r_last && take;
                rd_addr = hit.target;
            end
            dlpm_pkg::ST_WRB: begin
                wr_en = 1'b1;
                wr_data[r_slot*dlpm_pkg::ENTRY_W +: dlpm_pkg::ENTRY_W] =
                    {r_sv, r_lo, r_hi, r_tgt};
            end
            dlpm_pkg::ST_WRA: begin
                wr_en = 1'b1;
                wr_data[dlpm_pkg::ACC_BIT] = r_acc;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // scan context and results
    always_comb begin
        n_cur      = r_cur;
        n_dead     = r_dead;
        n_seen     = r_seen;
        n_bc       = r_bc;
        n_lai      = r_lai;
        n_pend     = r_pend;
        n_ppos     = r_ppos;
        n_res_m    = r_res_m;
        n_res_any  = r_res_any;
        n_res_lai  = r_res_lai;
        n_res_died = r_res_died;
        n_out_vld  = r_out_vld && i_out_stall;
        case (r_state)
            dlpm_pkg::ST_RES: begin
                // close the open accept check before the flag may change
                if (r_pend && flag) begin
                    n_seen = 1'b1;
                    n_lai  = {1'b0, r_ppos};
                end
                n_pend = 1'b0;
            end
            dlpm_pkg::ST_LOOK: begin
                n_seen = s_seen;
                n_lai  = s_lai;
                n_dead = s_dead;
                n_pend = 1'b0;
                if (begin_str) begin
                    n_cur = r_start_state;
                end
                if (r_op == dlpm_pkg::OP_FINISH) begin
                    n_res_m    = s_dead ? s_seen : flag;
                    n_res_any  = s_seen;
                    n_res_lai  = s_lai;
                    n_res_died = s_dead;
                    n_bc       = '0;
                    n_dead     = 1'b0;
                end else begin
                    if (!skip) begin
                        n_bc = r_bc + dlpm_pkg::BC_W'(1);
                        if (hit.hit) begin
                            n_cur  = hit.target;
                            n_pend = 1'b1;
                            n_ppos = pos_sat;
                        end else begin
                            n_dead = 1'b1;
                        end
                    end
                    if (r_last && !take) begin
                        n_res_m    = (s_dead || !skip) ? s_seen : flag;
                        n_res_any  = s_seen;
                        n_res_lai  = s_lai;
                        n_res_died = s_dead || !skip;
                        n_bc       = '0;
                        n_dead     = 1'b0;
                    end
                end
            end
            dlpm_pkg::ST_FIN: begin
                // row of the state the last byte entered
                n_res_m    = flag;
                n_res_any  = r_seen || flag;
                n_res_lai  = flag ? {1'b0, r_ppos} : r_lai;
                n_res_died = 1'b0;
                n_seen     = r_seen || flag;
                n_lai      = n_res_lai;
                n_pend     = 1'b0;
                n_bc       = '0;
                n_dead     = 1'b0;
            end
            dlpm_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dlpm_pkg::ST_IDLE;
            r_row_vld     <= '0;
            r_rd_vld      <= 1'b0;
            r_start_state <= '0;
            r_start_off   <= '0;
            r_cur         <= '0;
            r_dead        <= 1'b0;
            r_seen        <= 1'b0;
            r_bc          <= '0;
            r_lai         <= '1;
            r_pend        <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_dead    <= n_dead;
            r_seen    <= n_seen;
            r_bc      <= n_bc;
            r_lai     <= n_lai;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (dlpm_pkg::t_cfg_idx'(i_cfg_index))
                    dlpm_pkg::CFG_START_STATE:  r_start_state <= i_cfg_data[SW-1:0];
                    dlpm_pkg::CFG_START_OFFSET: r_start_off   <= i_cfg_data;
                    default:                    r_start_off   <= r_start_off;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ppos     <= n_ppos;
        r_res_m    <= n_res_m;
        r_res_any  <= n_res_any;
        r_res_lai  <= n_res_lai;
        r_res_died <= n_res_died;
        if (in_acc) begin
            r_op   <= in_op;
            r_ts   <= i_table_state;
            r_slot <= i_slot;
            r_sv   <= i_slot_valid;
            r_lo   <= i_range_low;
            r_hi   <= i_range_high;
            r_tgt  <= i_target_state;
            r_acc  <= i_accepting;
            r_byte <= i_text_byte;
            r_last <= i_last_byte;
        end
        if ((r_state == dlpm_pkg::ST_EMIT) && out_free) begin
            r_out_m    <= r_res_m;
            r_out_any  <= r_res_any;
            r_out_lai  <= r_res_lai;
            r_out_died <= r_res_died;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_matched    = r_out_m;
    assign o_any_prefix = r_out_any;
    assign o_last_index = $signed(r_out_lai);
    assign o_died       = r_out_died;

endmodule

>>> rtl/dlpm_checker.sv
module dlpm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [1:0]                 i_opcode,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_matched,
    input logic                       o_any_prefix,
    input logic signed [16:0]         o_last_index,
    input logic                       o_died
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a result held by the receiver does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_matched) && $stable(o_any_prefix)
             && $stable(o_last_index) && $stable(o_died)))
        else $error("stalled result changed");

    // two transactions are never accepted back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("accepted back to back");

    // table writes never produce a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ((i_opcode == dlpm_pkg::OP_BRANCH) || (i_opcode == dlpm_pkg::OP_ACCEPT)))
            |=> !$rose(o_out_valid))
        else $error("result from a table write");

    // a dead scan reports the prefix verdict
    a_dead_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_died) |-> (o_matched == o_any_prefix))
        else $error("dead scan verdict mismatch");

endmodule

bind dfa_longest_prefix_matcher dlpm_checker u_dlpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_opcode     (i_opcode),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_matched    (o_matched),
    .o_any_prefix (o_any_prefix),
    .o_last_index (o_last_index),
    .o_died       (o_died)
);
